@@ design/rte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and codes for the first-match route lookup: item structs,
// route entry, lookup token passed along the cell chain, and control states.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int IDX_W  = 4;
    localparam int PORT_W = 2;
    localparam int ADDR_W = 32;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_NUM_PORTS     = 4;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ROUTE = 2'd1;
    localparam logic [1:0] OP_ARP   = 2'd2;

    // result codes
    localparam logic [2:0] ACT_WRITTEN   = 3'd0;
    localparam logic [2:0] ACT_FORWARD   = 3'd1;
    localparam logic [2:0] ACT_ARP_REPLY = 3'd2;
    localparam logic [2:0] ACT_DROP      = 3'd3;
    localparam logic [2:0] ACT_OWN       = 3'd4;

    // kind bits
    localparam int KIND_GATE_BIT = 0;
    localparam int KIND_HOST_BIT = 1;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] entry_dest;
        logic [ADDR_W-1:0] entry_mask;
        logic [ADDR_W-1:0] entry_gateway;
        logic [PORT_W-1:0] entry_port;
        logic              entry_gate;
        logic              entry_host;
        logic              entry_valid;
        logic [ADDR_W-1:0] target_ip;
        logic [ADDR_W-1:0] sender_ip;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] next_hop_ip;
        logic [PORT_W-1:0] out_port;
        logic [IDX_W-1:0]  match_index;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic [1:0]        kind;
        logic              valid;
    } t_entry;

    typedef struct packed {
        logic              busy;
        logic              arp;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] sender;
        logic              found;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  idx;
    } t_token;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

@@ design/rte_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_cell
// One route table slot. Holds its entry and checks the passing lookup token,
// claiming it on the first hit, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module rte_cell
    import rte_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_we,
    input  t_entry i_wentry,
    input  t_token i_tok,
    output t_token o_tok
);

    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;
    logic   w_hit;

    // valid bit is control state; address fields stay undefined until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_we) begin
            r_entry <= i_wentry;
        end
    end

    assign w_hit = i_tok.busy && !i_tok.found && r_entry.valid
                   && (r_entry.dest == (r_entry.mask & i_tok.target))
                   && (i_tok.arp || (r_entry.kind != 2'b00));

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.port  = r_entry.port;
            n_tok.idx   = IDX_W'(IDX);
            if (i_tok.arp) begin
                n_tok.hop = i_tok.sender;
            end else if (r_entry.kind[KIND_GATE_BIT]) begin
                n_tok.hop = r_entry.gateway;
            end else begin
                n_tok.hop = i_tok.target;
            end
        end
    end

    // busy is control state; the token payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.busy <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ design/first_match_route_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_match_route_lookup
// Static route table with first-match IP forwarding and proxy ARP check,
// built as a chain of table cells that a lookup token walks through.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -----------------------
//  input     in         i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_ready   o_out_item (t_out_item)
//  config    in         i_cfg_we (no wait)          i_cfg_wdata (own_ip)
//
//  Flow: one item at a time. Writes, own-address route packets and unused
//  op codes give their result in the output register on the next cycle.
//  IP and ARP lookups pass the token one cell per cycle along the chain,
//  then the result from the last cell lands in the output register.
//  Reset clears every slot's valid bit directly; no clearing pass.
//  A stalled result holds the output register; a lookup that finishes
//  behind it parks in a pending register until the transfer completes.
//
module first_match_route_lookup
    import rte_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int NUM_PORTS     = DEF_NUM_PORTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata
);

    // highest legal port; written ports above it saturate to it
    localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(NUM_PORTS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_own_ip;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         r_pend;
    t_out_item         n_res;
    t_out_item         w_exit_res;
    logic              w_load;
    logic              w_launch;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_wr_item;
    t_entry            w_wentry;
    t_token            w_inject;
    t_token            w_tok [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_we;
    logic [TABLE_ENTRIES-1:0] w_busy;

    // own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we) begin
            r_own_ip <= i_cfg_wdata;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_wr_item  = w_in_acc && (i_in_item.op == OP_WRITE);

    // entry as stored: kind packs gate and host, port saturates
    always_comb begin
        w_wentry.dest    = i_in_item.entry_dest;
        w_wentry.mask    = i_in_item.entry_mask;
        w_wentry.gateway = i_in_item.entry_gateway;
        w_wentry.port    = (int'(i_in_item.entry_port) > NUM_PORTS - 1)
                           ? PORT_MAX : i_in_item.entry_port;
        w_wentry.kind    = {i_in_item.entry_host, i_in_item.entry_gate};
        w_wentry.valid   = i_in_item.entry_valid;
    end

    // token entering the first cell
    always_comb begin
        w_inject        = '0;
        w_inject.busy   = w_launch;
        w_inject.arp    = (i_in_item.op == OP_ARP);
        w_inject.target = i_in_item.target_ip;
        w_inject.sender = i_in_item.sender_ip;
    end

    assign w_tok[0] = w_inject;

    // the chain: one cell per slot, token advances one cell per cycle
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        // slots beyond the 4-bit index range are never written
        assign w_we[k]   = w_wr_item && (int'(i_in_item.entry_index) == k);
        assign w_busy[k] = w_tok[k+1].busy;

        rte_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (w_we[k]),
            .i_wentry (w_wentry),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    // result carried out of the last cell
    always_comb begin
        w_exit_res = '0;
        if (w_tok[TABLE_ENTRIES].found) begin
            w_exit_res.action      = w_tok[TABLE_ENTRIES].arp ? ACT_ARP_REPLY
                                                              : ACT_FORWARD;
            w_exit_res.next_hop_ip = w_tok[TABLE_ENTRIES].hop;
            w_exit_res.out_port    = w_tok[TABLE_ENTRIES].port;
            w_exit_res.match_index = w_tok[TABLE_ENTRIES].idx;
        end else begin
            w_exit_res.action = ACT_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencing: answer at once, or launch a token and wait for it
    always_comb begin
        n_state  = r_state;
        w_load   = 1'b0;
        w_launch = 1'b0;
        n_res    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_item.op)
                        OP_WRITE: begin
                            w_load       = 1'b1;
                            n_res.action = ACT_WRITTEN;
                        end
                        OP_ROUTE: begin
                            if (i_in_item.target_ip == r_own_ip) begin
                                w_load       = 1'b1;
                                n_res.action = ACT_OWN;
                            end else begin
                                w_launch = 1'b1;
                                n_state  = ST_RUN;
                            end
                        end
                        OP_ARP: begin
                            w_launch = 1'b1;
                            n_state  = ST_RUN;
                        end
                        default: begin
                            w_load       = 1'b1;
                            n_res.action = ACT_DROP;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_tok[TABLE_ENTRIES].busy) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_res   = w_exit_res;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_res   = r_pend;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // park a finished lookup while the output register is still full
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && w_tok[TABLE_ENTRIES].busy) begin
            r_pend <= w_exit_res;
        end
    end

    // output register: load a fresh result, drop the old one on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_busy) <= 1)
        else $error("more than one lookup token in the chain");

    a_exit_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].busy |-> (r_state == ST_RUN))
        else $error("token left the chain outside a lookup");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |-> ##(TABLE_ENTRIES) w_tok[TABLE_ENTRIES].busy)
        else $error("lookup token did not leave the chain on time");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.action == ACT_OWN
                         || r_out_item.action == ACT_WRITTEN
                         || r_out_item.action == ACT_DROP))
        |-> (r_out_item.next_hop_ip == '0 && r_out_item.out_port == '0
             && r_out_item.match_index == '0))
        else $error("result without a match carries match fields");
`endif

endmodule
